[hdl/sobm_pkg.sv]
// ----------------------------------------------------------------------------
// sobm_pkg
// shared types and codes of the shift-or byte matcher
// ----------------------------------------------------------------------------
package sobm_pkg;

    typedef logic [1:0]  cmd_t;
    typedef logic [5:0]  pidx_t;
    typedef logic [7:0]  byte_t;
    typedef logic [6:0]  len_t;
    typedef logic [47:0] pos_t;
    typedef logic [31:0] count_t;

    // command codes on the input channel
    localparam cmd_t CMD_LOAD    = 2'd0;
    localparam cmd_t CMD_TEXT    = 2'd1;
    localparam cmd_t CMD_NEWFILE = 2'd2;

    // operations after classification
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_TEXT    = 2'd2,
        OP_NEWFILE = 2'd3
    } op_t;

    typedef struct packed {
        op_t   op;
        pidx_t index;
        byte_t data;
    } entry_t;

endpackage

[hdl/sobm_in_if.sv]
// ----------------------------------------------------------------------------
// sobm_in_if
// input item channel: command, pattern index and data byte
// ----------------------------------------------------------------------------
interface sobm_in_if;

    logic             valid;
    logic             ready;
    sobm_pkg::cmd_t   command;
    sobm_pkg::pidx_t  pattern_index;
    sobm_pkg::byte_t  data_byte;

    modport source (output valid, output command, output pattern_index,
                    output data_byte, input ready);
    modport sink   (input valid, input command, input pattern_index,
                    input data_byte, output ready);

endinterface

[hdl/sobm_out_if.sv]
// ----------------------------------------------------------------------------
// sobm_out_if
// result channel: match flag, match start offset and running match count
// ----------------------------------------------------------------------------
interface sobm_out_if;

    logic              valid;
    logic              ready;
    logic              match_found;
    sobm_pkg::pos_t    match_start;
    sobm_pkg::count_t  match_count;

    modport source (output valid, output match_found, output match_start,
                    output match_count, input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input match_count, output ready);

endinterface

[hdl/sobm_front.sv]
// ----------------------------------------------------------------------------
// sobm_front
// accepts input items, classifies the command and queues the operation
// ----------------------------------------------------------------------------
module sobm_front #(
    parameter int PATTERN_MAX = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    sobm_in_if.sink           items,
    output logic              q_valid,
    output sobm_pkg::entry_t  q_entry,
    input  logic              q_pop
);

    sobm_pkg::entry_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    sobm_pkg::entry_t cls;

    assign items.ready = (count_reg != 2'd2);
    assign push        = items.valid && items.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign q_entry     = entry_reg[rd_ptr_reg];

    // loads beyond the store and the unused code turn into no-ops
    always_comb
    begin
        cls.index = items.pattern_index;
        cls.data  = items.data_byte;
        unique case (items.command)
            sobm_pkg::CMD_LOAD:
            begin
                if ({1'b0, items.pattern_index} < sobm_pkg::len_t'(PATTERN_MAX))
                    cls.op = sobm_pkg::OP_LOAD;
                else
                    cls.op = sobm_pkg::OP_NONE;
            end
            sobm_pkg::CMD_TEXT:    cls.op = sobm_pkg::OP_TEXT;
            sobm_pkg::CMD_NEWFILE: cls.op = sobm_pkg::OP_NEWFILE;
            default:               cls.op = sobm_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cls;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on transfer");
`endif

endmodule

[hdl/sobm_back.sv]
// ----------------------------------------------------------------------------
// sobm_back
// executes queued operations: pattern store, shift-or update, result register
// ----------------------------------------------------------------------------
module sobm_back #(
    parameter int PATTERN_MAX = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sobm_pkg::entry_t  q_entry,
    output logic              q_pop,
    input  sobm_pkg::len_t    pattern_length,
    sobm_out_if.source        results
);

    localparam int SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    sobm_pkg::byte_t   store_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] vec_reg;
    logic [PATTERN_MAX-1:0] vec_next;
    logic [PATTERN_MAX-1:0] mask;
    logic [PATTERN_MAX-1:0] vec_upd;
    sobm_pkg::pos_t    pos_reg;
    sobm_pkg::pos_t    pos_next;
    sobm_pkg::count_t  count_reg;
    sobm_pkg::count_t  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    sobm_pkg::pos_t    out_start_reg;
    sobm_pkg::count_t  out_count_reg;
    logic              len_ok;
    sobm_pkg::len_t    len_m1;
    logic              hit;
    sobm_pkg::pos_t    start;
    logic              is_text;

    assign q_pop   = q_valid && (!out_valid_reg || results.ready);
    assign is_text = (q_entry.op == sobm_pkg::OP_TEXT);

    // one compare lane per pattern position
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
            mask[i] = !((sobm_pkg::len_t'(i) < pattern_length)
                        && (store_reg[i] == q_entry.data));
    end

    assign vec_upd = (vec_reg << 1) | mask;
    assign len_ok  = (pattern_length != '0)
                     && (pattern_length <= sobm_pkg::len_t'(PATTERN_MAX));
    assign len_m1  = pattern_length - sobm_pkg::len_t'(1);
    assign hit     = len_ok && !vec_upd[len_m1[SEL_W-1:0]];
    assign start   = pos_reg - sobm_pkg::pos_t'(len_m1);

    always_comb
    begin
        vec_next   = vec_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        if (q_pop)
        begin
            case (q_entry.op)
                sobm_pkg::OP_TEXT:
                begin
                    vec_next = vec_upd;
                    pos_next = pos_reg + sobm_pkg::pos_t'(1);
                    if (hit && (count_reg != '1))
                        count_next = count_reg + sobm_pkg::count_t'(1);
                end
                sobm_pkg::OP_NEWFILE:
                begin
                    vec_next = '1;
                    pos_next = '0;
                end
                default:
                begin
                    vec_next = vec_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg       <= '1;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vec_reg       <= vec_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_entry.op == sobm_pkg::OP_LOAD))
            store_reg[q_entry.index[SEL_W-1:0]] <= q_entry.data;
        if (q_pop)
        begin
            out_found_reg <= is_text && hit;
            out_start_reg <= (is_text && hit) ? start : '0;
            out_count_reg <= count_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.match_found = out_found_reg;
    assign results.match_start = out_start_reg;
    assign results.match_count = out_count_reg;

`ifndef SYNTHESIS
    a_newfile_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_entry.op == sobm_pkg::OP_NEWFILE)
        |=> (pos_reg == '0) && (vec_reg == '1))
        else $error("new file did not clear search state");

    a_nomatch_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_start_reg == '0)
        else $error("start offset set without a match");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |-> out_count_reg != '0)
        else $error("match reported with zero count");
`endif

endmodule

[hdl/shift_or_byte_matcher.sv]
// ----------------------------------------------------------------------------
// shift_or_byte_matcher
// shift-or exact string matcher over a byte stream
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  items     in    valid/ready     command, pattern_index, data_byte
//  results   out   valid/ready     match_found, match_start, match_count
//  cfg       in    cfg_we          cfg_wdata = pattern_length
//
//  one item per cycle sustained while results are taken; an item is queued on
//  transfer and its result is registered once the result register is free;
//  the shift-or update (parallel byte compare, shift, or) is combinational
//  reset: vector all ones, position and count zero, pattern length one;
//  the pattern store is not cleared
//  stalls: the queue absorbs two items while the result register waits
// ----------------------------------------------------------------------------
module shift_or_byte_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    sobm_in_if.sink         items,
    sobm_out_if.source      results,
    input  logic            cfg_we,
    input  sobm_pkg::len_t  cfg_wdata
);

    sobm_pkg::len_t   len_reg;
    logic             q_valid;
    logic             q_pop;
    sobm_pkg::entry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= sobm_pkg::len_t'(1);
        else if (cfg_we)
            len_reg <= cfg_wdata;
    end

    sobm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    sobm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .pattern_length (len_reg),
        .results        (results)
    );

endmodule
